// ===== hdl/banked_memory_map_decoder_unit_assert.svh =====
// Assertion macros for the banked memory map decoder.
// Used by the top level; no other dependencies.
`ifndef BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH
`define BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent holds -> consequent holds in the same cycle
`define BMMD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define BMMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BMMD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BMMD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bmmd_pkg.sv =====
// Shared types and constants of the banked memory map decoder.
// No dependencies.
package bmmd_pkg;

   // decode targets
   typedef enum logic [3:0] {
      TGT_DIR    = 4'd0,
      TGT_PORT   = 4'd1,
      TGT_RAM    = 4'd2,
      TGT_CART   = 4'd3,
      TGT_BASIC  = 4'd4,
      TGT_KERNEL = 4'd5,
      TGT_CHAR   = 4'd6,
      TGT_VIDEO  = 4'd7,
      TGT_IO1    = 4'd8,
      TGT_IO2    = 4'd9,
      TGT_OPEN   = 4'd10,
      TGT_DROP   = 4'd11
   } target_type;

   // access kinds
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // processor port
   localparam logic [15:0] ADDR_DIR      = 16'h0000;
   localparam logic [15:0] ADDR_PORT     = 16'h0001;
   localparam logic [7:0]  PORT_DIR_RST  = 8'h2F;
   localparam logic [7:0]  PORT_DATA_RST = 8'h37;
   localparam logic [7:0]  PORT_TOP_BITS = 8'hC0;
   localparam logic [7:0]  OPEN_BUS_DATA = 8'hFF;

   // map boundaries
   localparam logic [15:0] CART_LO   = 16'h8000;
   localparam logic [15:0] CART_HI   = 16'hBFFF;
   localparam logic [15:0] BASIC_LO  = 16'hA000;
   localparam logic [15:0] KERNEL_LO = 16'hE000;
   localparam logic [15:0] WIN_LO    = 16'hD000;
   localparam logic [15:0] WIN_HI    = 16'hDFFF;
   localparam logic [15:0] VID_HI    = 16'hD3FF;
   localparam logic [15:0] COLOR_LO  = 16'hD800;
   localparam logic [15:0] COLOR_HI  = 16'hDBFF;
   localparam logic [15:0] IO1_LO    = 16'hDC00;
   localparam logic [15:0] IO1_HI    = 16'hDCFF;
   localparam logic [15:0] IO2_LO    = 16'hDD00;
   localparam logic [15:0] IO2_HI    = 16'hDDFF;

   // configuration register map
   localparam int          CSR_ADDR_W      = 3;
   localparam logic [2:0]  CSR_CART_ADDR   = 3'd0;

   // decode result with port register update
   typedef struct packed {
      target_type  target;
      logic [15:0] offset;
      logic [7:0]  read_data;
      logic        dir_wr;
      logic        port_wr;
      logic [7:0]  dir_next;
      logic [7:0]  port_next;
   } decode_type;

endpackage

// ===== hdl/banked_memory_map_decoder_unit.sv =====
// Banked memory map decoder, top level: input register, decode, result
// register and processor port registers. Depends on bmmd_pkg, bmmd_csr,
// bmmd_decode and banked_memory_map_decoder_unit_assert.svh.
//
// Usage:
//   The req_ channel carries one bus access per word (req_type, req_bus_addr,
//   req_write_data); the rsp_ channel returns one decoded word per access
//   (rsp_target, rsp_target_offset, rsp_read_data), in order.
//   A word is moved when valid is high and stall is low.
//   The input register loads at the accepting edge; the result register loads
//   from it once rsp_stall allows, and rsp_valid rises as it does.
//   Throughput: one access per cycle while rsp_stall is low; the decode and
//   the port register update sit between those two registers.
//   Port register writes take effect for the very next access.
//   When rsp_stall is held, the result register holds its word, one more
//   access is taken into the input register, and req_stall then rises.
//   The APB-style port holds cartridge_present at byte address 0; pready is
//   always high. Write it only while the block is empty.
//   Reset (synchronous, active high) empties both registers, clears
//   cartridge_present and loads the port direction with 0x2F, data with 0x37.
`include "banked_memory_map_decoder_unit_assert.svh"
module banked_memory_map_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   // access channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [15:0]                      req_bus_addr,
   input  logic [7:0]                       req_write_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [3:0]                       rsp_target,
   output logic [15:0]                      rsp_target_offset,
   output logic [7:0]                       rsp_read_data,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmmd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import bmmd_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic        in_type_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_data_ff;
   logic        out_vld_ff, out_vld_in;
   target_type  out_tgt_ff;
   logic [15:0] out_off_ff;
   logic [7:0]  out_rd_ff;
   logic [7:0]  dir_ff, dir_in;
   logic [7:0]  pdata_ff, pdata_in;
   logic        cart_present;
   logic        in_load, adv;
   decode_type  dec;

   // configuration register
   bmmd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .cart_present (cart_present)
   );

   // decode of the word in the input register
   bmmd_decode u_decode (
      .acc_type     (in_type_ff),
      .addr         (in_addr_ff),
      .wdata        (in_data_ff),
      .port_dir     (dir_ff),
      .port_data    (pdata_ff),
      .cart_present (cart_present),
      .dec          (dec)
   );

   // flow control
   assign adv        = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !adv;
   assign in_load    = req_valid && !req_stall;
   assign in_vld_in  = in_load || (in_vld_ff && !adv);
   assign out_vld_in = adv || (out_vld_ff && rsp_stall);

   // port register update as the word moves to the result register
   assign dir_in   = (adv && dec.dir_wr)  ? dec.dir_next  : dir_ff;
   assign pdata_in = (adv && dec.port_wr) ? dec.port_next : pdata_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         dir_ff     <= PORT_DIR_RST;
         pdata_ff   <= PORT_DATA_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         dir_ff     <= dir_in;
         pdata_ff   <= pdata_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_type_ff <= req_type;
         in_addr_ff <= req_bus_addr;
         in_data_ff <= req_write_data;
      end
      if (adv) begin
         out_tgt_ff <= dec.target;
         out_off_ff <= dec.offset;
         out_rd_ff  <= dec.read_data;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_target        = out_tgt_ff;
   assign rsp_target_offset = out_off_ff;
   assign rsp_read_data     = out_rd_ff;

   // checks
   `BMMD_ASSERT_NEXT(a_port_top_bits, clock, reset, adv && dec.port_wr, pdata_ff[7:6] == 2'b11)
   `BMMD_ASSERT_IMPL(a_open_bus_data, clock, reset, out_vld_ff && (out_tgt_ff == TGT_OPEN), out_rd_ff == OPEN_BUS_DATA)
   `BMMD_ASSERT_NEXT(a_dir_written, clock, reset, adv && dec.dir_wr, dir_ff == out_rd_ff)

endmodule

// ===== hdl/bmmd_csr.sv =====
// Configuration register block: APB-style port holding cartridge_present.
// Depends on bmmd_pkg.
module bmmd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bmmd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output logic                             cart_present
);
   import bmmd_pkg::*;

   logic cart_ff;
   logic cart_in;
   logic wr_hit;

   assign pready = 1'b1;

   // write decode, access phase
   assign wr_hit  = psel && penable && pwrite && (paddr == CSR_CART_ADDR);
   assign cart_in = wr_hit ? pwdata[0] : cart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_ff <= 1'b0;
      end else begin
         cart_ff <= cart_in;
      end
   end

   // read mux
   always_comb begin
      prdata = 32'd0;
      if (paddr == CSR_CART_ADDR) begin
         prdata = {31'd0, cart_ff};
      end
   end

   assign cart_present = cart_ff;

endmodule

// ===== hdl/bmmd_decode.sv =====
// Address decoder: maps one bus access to a target, offset and read word,
// and computes the processor port register update. Depends on bmmd_pkg.
module bmmd_decode (
   input  logic                  acc_type,
   input  logic [15:0]           addr,
   input  logic [7:0]            wdata,
   input  logic [7:0]            port_dir,
   input  logic [7:0]            port_data,
   input  logic                  cart_present,
   output bmmd_pkg::decode_type  dec
);
   import bmmd_pkg::*;

   logic basic_on, kernel_on, window_on, char_on, cart_on;
   logic in_win, in_cart, in_basic, in_kernel;
   target_type io_tgt;

   // banking controls from the port data register
   assign basic_on  = (port_data[1:0] == 2'b11);
   assign kernel_on = port_data[1];
   assign window_on = (port_data[1:0] != 2'b00);
   assign char_on   = !port_data[2];
   assign cart_on   = cart_present && basic_on;

   assign in_win    = (addr >= WIN_LO) && (addr <= WIN_HI);
   assign in_cart   = (addr >= CART_LO) && (addr <= CART_HI);
   assign in_basic  = (addr >= BASIC_LO) && (addr <= CART_HI);
   assign in_kernel = (addr >= KERNEL_LO);

   // device select inside the I/O window
   always_comb begin
      if (((addr >= WIN_LO) && (addr <= VID_HI)) ||
          ((addr >= COLOR_LO) && (addr <= COLOR_HI))) begin
         io_tgt = TGT_VIDEO;
      end else if ((addr >= IO1_LO) && (addr <= IO1_HI)) begin
         io_tgt = TGT_IO1;
      end else if ((addr >= IO2_LO) && (addr <= IO2_HI)) begin
         io_tgt = TGT_IO2;
      end else begin
         io_tgt = TGT_OPEN;
      end
   end

   // priority decode
   always_comb begin
      dec.target    = TGT_RAM;
      dec.offset    = addr;
      dec.read_data = 8'd0;
      dec.dir_wr    = 1'b0;
      dec.port_wr   = 1'b0;
      dec.dir_next  = wdata;
      dec.port_next = PORT_TOP_BITS | (port_data & ~port_dir) | (wdata & port_dir);
      if (acc_type == ACC_WRITE) begin
         if (addr == ADDR_DIR) begin
            dec.target    = TGT_DIR;
            dec.dir_wr    = 1'b1;
            dec.read_data = dec.dir_next;
         end else if (addr == ADDR_PORT) begin
            dec.target    = TGT_PORT;
            dec.port_wr   = 1'b1;
            dec.read_data = dec.port_next;
         end else if (in_win && window_on) begin
            dec.target = (io_tgt == TGT_OPEN) ? TGT_DROP : io_tgt;
         end
      end else begin
         if (addr == ADDR_DIR) begin
            dec.target    = TGT_DIR;
            dec.read_data = port_dir;
         end else if (addr == ADDR_PORT) begin
            dec.target    = TGT_PORT;
            dec.read_data = port_data;
         end else if (cart_on && in_cart) begin
            dec.target = TGT_CART;
            dec.offset = {2'b00, addr[13:0]};
         end else if (basic_on && in_basic) begin
            // A000..BFFF minus base is the low 13 bits
            dec.target = TGT_BASIC;
            dec.offset = {3'b000, addr[12:0]};
         end else if (kernel_on && in_kernel) begin
            dec.target = TGT_KERNEL;
            dec.offset = {3'b000, addr[12:0]};
         end else if (in_win && window_on) begin
            if (char_on) begin
               dec.target = TGT_CHAR;
               dec.offset = {4'b0000, addr[11:0]};
            end else begin
               dec.target = io_tgt;
               if (io_tgt == TGT_OPEN) begin
                  dec.read_data = OPEN_BUS_DATA;
               end
            end
         end
      end
   end

endmodule

// ===== test/banked_memory_map_decoder_unit_tb.sv =====
// Self-checking testbench for banked_memory_map_decoder_unit: bus accesses go in
// with random gaps, decoded words come back under random stalls and are checked
// against an in-bench model of the port registers and the map. Needs bmmd_pkg.
module banked_memory_map_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmmd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_WAIT    = 10;

   // one decoded word as the block should return it
   typedef struct {
      target_type  target;
      logic [15:0] offset;
      logic [7:0]  read_data;
   } decoded_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = ACC_READ;
   logic [15:0] req_bus_addr = '0;
   logic [7:0]  req_write_data = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_target;
   logic [15:0] rsp_target_offset;
   logic [7:0]  rsp_read_data;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // model state: processor port registers and cartridge switch
   logic [7:0] port_dir = PORT_DIR_RST;
   logic [7:0] port_val = PORT_DATA_RST;
   logic       cart_present = 1'b0;

   decoded_word_type pending_words[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;

   // boundaries of the map, probed at +-1 by the random traffic
   logic [15:0] map_bounds[13] = '{CART_LO, CART_HI, BASIC_LO, KERNEL_LO, WIN_LO, WIN_HI,
                                   VID_HI, COLOR_LO, COLOR_HI, IO1_LO, IO1_HI, IO2_LO,
                                   IO2_HI};

   banked_memory_map_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_bus_addr      (req_bus_addr),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_target        (rsp_target),
      .rsp_target_offset (rsp_target_offset),
      .rsp_read_data     (rsp_read_data),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   // device behind an address of the D000-DFFF window
   function automatic target_type device_at(input logic [15:0] addr);
      if ((addr >= WIN_LO && addr <= VID_HI) || (addr >= COLOR_LO && addr <= COLOR_HI))
         return TGT_VIDEO;
      if (addr >= IO1_LO && addr <= IO1_HI)
         return TGT_IO1;
      if (addr >= IO2_LO && addr <= IO2_HI)
         return TGT_IO2;
      return TGT_OPEN;
   endfunction

   // decode one access against the current banking, updating the port registers
   function automatic decoded_word_type decode_access(input logic kind,
                                                      input logic [15:0] addr,
                                                      input logic [7:0] data);
      decoded_word_type w;
      logic basic_on, kernel_on, window_on, char_on, cart_on, in_window;
      basic_on  = port_val[1:0] == 2'b11;
      kernel_on = port_val[1];
      window_on = port_val[1:0] != 2'b00;
      char_on   = !port_val[2];
      cart_on   = cart_present && basic_on;
      in_window = addr >= WIN_LO && addr <= WIN_HI;
      w.target    = TGT_RAM;
      w.offset    = addr;
      w.read_data = '0;
      if (kind == ACC_WRITE) begin
         if (addr == ADDR_DIR) begin
            port_dir    = data;
            w.target    = TGT_DIR;
            w.read_data = port_dir;
         end else if (addr == ADDR_PORT) begin
            // masked write: only direction-enabled bits change, top two read as 1
            port_val    = PORT_TOP_BITS | (port_val & ~port_dir) | (data & port_dir);
            w.target    = TGT_PORT;
            w.read_data = port_val;
         end else if (in_window && window_on) begin
            w.target = device_at(addr);
            if (w.target == TGT_OPEN)
               w.target = TGT_DROP;
         end
      end else begin
         if (addr == ADDR_DIR) begin
            w.target    = TGT_DIR;
            w.read_data = port_dir;
         end else if (addr == ADDR_PORT) begin
            w.target    = TGT_PORT;
            w.read_data = port_val;
         end else if (cart_on && addr >= CART_LO && addr <= CART_HI) begin
            w.target = TGT_CART;
            w.offset = addr & 16'h3FFF;
         end else if (basic_on && addr >= BASIC_LO && addr <= CART_HI) begin
            w.target = TGT_BASIC;
            w.offset = addr - BASIC_LO;
         end else if (kernel_on && addr >= KERNEL_LO) begin
            w.target = TGT_KERNEL;
            w.offset = addr - KERNEL_LO;
         end else if (in_window && window_on) begin
            if (char_on) begin
               w.target = TGT_CHAR;
               w.offset = addr & 16'h0FFF;
            end else begin
               w.target = device_at(addr);
               if (w.target == TGT_OPEN)
                  w.read_data = OPEN_BUS_DATA;
            end
         end
      end
      return w;
   endfunction

   // send one access word; returns at the edge where it was taken
   task automatic send_access(input logic kind, input logic [15:0] addr,
                              input logic [7:0] data);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_bus_addr   <= addr;
      req_write_data <= data;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_words.push_back(decode_access(kind, addr, data));
   endtask

   // stop sending and let every outstanding word come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one APB transfer: setup, then access until pready
   task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_CART_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // set cartridge_present while the block is empty, then read it back
   task automatic set_cartridge(input logic present);
      logic [31:0] rdata;
      drain_results();
      apb_transfer(1'b1, {31'($urandom), present}, rdata);
      cart_present = present;
      @(posedge clock);
      apb_transfer(1'b0, '0, rdata);
      if (rdata[0] !== present) begin
         $error("cartridge_present: expected %0d, got %0d", present, rdata[0]);
         fail_count++;
      end
   endtask

   // address mix that favors the port, the window, ROM areas and boundaries
   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 1));
         1: return 16'($urandom_range(WIN_LO, WIN_HI));
         2: return map_bounds[$urandom_range(0, 12)] + 16'($urandom_range(0, 2)) - 16'd1;
         3: return 16'($urandom_range(CART_LO, CART_HI));
         4: return 16'($urandom_range(KERNEL_LO, 16'hFFFF));
         default: return 16'($urandom);
      endcase
   endfunction

   // map at reset: port values, ROMs, window devices, open bus
   task automatic test_reset_map();
      send_access(ACC_READ, ADDR_DIR, 8'hFF);
      send_access(ACC_READ, ADDR_PORT, 8'h00);
      send_access(ACC_READ, 16'hFFFF, 8'h00);
      send_access(ACC_READ, KERNEL_LO, 8'h00);
      send_access(ACC_READ, BASIC_LO, 8'h00);
      send_access(ACC_READ, CART_HI, 8'h00);
      send_access(ACC_READ, CART_LO, 8'h00);
      send_access(ACC_READ, WIN_LO, 8'h00);
      send_access(ACC_READ, WIN_HI, 8'h00);
      send_access(ACC_READ, 16'hD400, 8'h00);
      send_access(ACC_READ, IO1_LO, 8'h00);
      send_access(ACC_READ, IO2_HI, 8'h00);
      send_access(ACC_READ, COLOR_HI, 8'h00);
      // writes under ROM land in RAM; unmapped window write is dropped
      send_access(ACC_WRITE, BASIC_LO, 8'hA5);
      send_access(ACC_WRITE, 16'hD7FF, 8'h5A);
      send_access(ACC_WRITE, IO1_HI, 8'hFF);
      send_access(ACC_READ, 16'h0002, 8'h00);
   endtask

   // masked port writes and every banking mode of the low port bits
   task automatic test_port_banking();
      send_access(ACC_WRITE, ADDR_DIR, 8'hFF);
      send_access(ACC_WRITE, ADDR_PORT, 8'h00);
      send_access(ACC_READ, KERNEL_LO, 8'h00);
      send_access(ACC_READ, WIN_LO, 8'h00);
      send_access(ACC_WRITE, WIN_LO, 8'h11);
      send_access(ACC_WRITE, ADDR_PORT, 8'h01);
      send_access(ACC_READ, WIN_LO, 8'h00);
      send_access(ACC_READ, WIN_HI, 8'h00);
      send_access(ACC_WRITE, WIN_LO, 8'h22);
      send_access(ACC_WRITE, 16'hDE00, 8'h33);
      send_access(ACC_WRITE, ADDR_PORT, 8'h02);
      send_access(ACC_READ, KERNEL_LO, 8'h00);
      send_access(ACC_READ, BASIC_LO, 8'h00);
      // direction 0 freezes the data register
      send_access(ACC_WRITE, ADDR_DIR, 8'h00);
      send_access(ACC_WRITE, ADDR_PORT, 8'hFF);
      send_access(ACC_READ, ADDR_PORT, 8'h00);
      send_access(ACC_WRITE, ADDR_DIR, PORT_DIR_RST);
      send_access(ACC_WRITE, ADDR_PORT, PORT_DATA_RST);
      send_access(ACC_READ, ADDR_DIR, 8'h00);
   endtask

   // cartridge overlay on and off, and its dependence on BASIC banking
   task automatic test_cartridge();
      set_cartridge(1'b1);
      send_access(ACC_READ, CART_LO, 8'h00);
      send_access(ACC_READ, CART_HI, 8'h00);
      send_access(ACC_READ, BASIC_LO, 8'h00);
      send_access(ACC_WRITE, CART_LO, 8'h77);
      send_access(ACC_WRITE, ADDR_PORT, 8'h36);
      send_access(ACC_READ, CART_LO, 8'h00);
      send_access(ACC_WRITE, ADDR_PORT, PORT_DATA_RST);
      set_cartridge(1'b0);
      send_access(ACC_READ, CART_LO, 8'h00);
      send_access(ACC_READ, CART_HI, 8'h00);
   endtask

   // mixed random traffic; idling modes change every few dozen words
   task automatic run_random_traffic(input int count);
      logic        kind;
      logic [15:0] addr;
      logic [7:0]  data;
      int          sel;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
         end
         sel  = $urandom_range(0, 19);
         data = 8'($urandom);
         kind = ACC_WRITE;
         if (sel < 2) begin
            addr = ADDR_DIR;
            // keep the banking bits writable most of the time
            if ($urandom_range(0, 3) != 0)
               data = data | 8'h07;
         end else if (sel < 5) begin
            addr = ADDR_PORT;
         end else begin
            addr = pick_addr();
            if (sel >= 8)
               kind = ACC_READ;
         end
         send_access(kind, addr, data);
      end
   endtask

   task automatic test_random_traffic();
      set_cartridge(1'b1);
      run_random_traffic(600);
      set_cartridge(1'b0);
      run_random_traffic(600);
      set_cartridge(1'b1);
      run_random_traffic(500);
   endtask

   // result checker and stall generator
   always @(posedge clock) begin
      decoded_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word: target %0d offset %h data %h",
                      rsp_target, rsp_target_offset, rsp_read_data);
               fail_count++;
            end else begin
               w = pending_words.pop_front();
               if (rsp_target !== w.target) begin
                  $error("target: expected %0d, got %0d", w.target, rsp_target);
                  fail_count++;
               end
               if (rsp_target_offset !== w.offset) begin
                  $error("target_offset: expected %h, got %h", w.offset, rsp_target_offset);
                  fail_count++;
               end
               if (rsp_read_data !== w.read_data) begin
                  $error("read_data: expected %h, got %h", w.read_data, rsp_read_data);
                  fail_count++;
               end
            end
            stall_left = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= stall_left != 0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_map();
      test_port_banking();
      test_cartridge();
      test_random_traffic();
      drain_results();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
